// File: rtl/ihex_enc_pkg.sv
// Shared types, constants and helpers for the Intel HEX record encoder.
package ihex_enc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_START_GIVEN   = 2'd2;
    localparam logic [1:0] CFG_START_ADDRESS = 2'd3;

    // Input item modes.
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Fixed record text.
    localparam logic [71:0] EXT_HEAD   = ":02000004";
    localparam logic [71:0] START_HEAD = ":04000005";
    localparam logic [87:0] END_TEXT   = ":00000001FF";
    localparam logic [15:0] TYPE_DATA  = "00";
    localparam logic [7:0]  CHAR_COLON = ":";
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_ERROR = 8'h00;

    // Byte count plus record type, folded into the fixed records' checksums.
    localparam logic [7:0] EXT_SUM_BASE   = 8'h06;
    localparam logic [7:0] START_SUM_BASE = 8'h09;

    // Everything the serializer needs to print the records of one item.
    typedef struct packed {
        logic        err;
        logic        fin;
        logic        start;
        logic        ext;
        logic        hdr;
        logic        close;
        logic [15:0] upper;
        logic [7:0]  ext_sum;
        logic [7:0]  len;
        logic [15:0] lower;
        logic [7:0]  data;
        logic [7:0]  close_sum;
        logic [31:0] start_addr;
        logic [7:0]  start_sum;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

    function automatic logic [15:0] hex_byte(input logic [7:0] v);
        hex_byte = {hex_char(v[7:4]), hex_char(v[3:0])};
    endfunction

endpackage

// File: rtl/ihex_enc_front.sv
// Record planner: configuration registers, image state and per-item job build.
module ihex_enc_front #(
    parameter int RECORD_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_accept,
    input  logic                i_mode,
    input  logic [7:0]          i_data_byte,
    output logic                o_load,
    output ihex_enc_pkg::t_job  o_job
);

    localparam int PosW = $clog2(RECORD_BYTES + 1);

    logic [31:0]     r_base_address;
    logic [31:0]     r_image_length;
    logic            r_start_given;
    logic [31:0]     r_start_address;
    logic [31:0]     r_byte_offset;
    logic [7:0]      r_record_sum;
    logic [15:0]     r_last_upper;
    logic [PosW-1:0] r_record_pos;

    logic [31:0]     addr;
    logic [31:0]     remaining;
    logic            in_range;
    logic            rec_open;
    logic            ext_needed;
    logic [7:0]      len;
    logic [7:0]      hdr_sum;
    logic [7:0]      n_record_sum;
    logic [PosW-1:0] n_record_pos;
    logic            close_rec;
    logic            fin_err;
    logic [7:0]      start_bytes;

    assign addr         = r_base_address + r_byte_offset;
    assign remaining    = r_image_length - r_byte_offset;
    assign in_range     = r_byte_offset < r_image_length;
    assign rec_open     = r_record_pos == '0;
    assign ext_needed   = rec_open && (addr[31:16] != r_last_upper);
    assign len          = (remaining < 32'(RECORD_BYTES)) ? remaining[7:0] : 8'(RECORD_BYTES);
    assign hdr_sum      = len + addr[7:0] + addr[15:8];
    assign n_record_sum = (rec_open ? hdr_sum : r_record_sum) + i_data_byte;
    assign n_record_pos = r_record_pos + 1'b1;
    // While a byte is in range, the offset reaches the length exactly when one byte remains.
    assign close_rec    = (n_record_pos >= PosW'(RECORD_BYTES)) || (remaining == 32'd1);
    assign fin_err      = in_range || !rec_open;
    assign start_bytes  = r_start_address[7:0] + r_start_address[15:8]
                        + r_start_address[23:16] + r_start_address[31:24];

    assign o_load = i_accept && ((i_mode == ihex_enc_pkg::MODE_FINISH) || in_range);

    always_comb begin
        o_job            = '0;
        o_job.err        = (i_mode == ihex_enc_pkg::MODE_FINISH) && fin_err;
        o_job.fin        = i_mode == ihex_enc_pkg::MODE_FINISH;
        o_job.start      = r_start_given;
        o_job.ext        = ext_needed;
        o_job.hdr        = rec_open;
        o_job.close      = close_rec;
        o_job.upper      = addr[31:16];
        o_job.ext_sum    = 8'h00 - (ihex_enc_pkg::EXT_SUM_BASE + addr[23:16] + addr[31:24]);
        o_job.len        = len;
        o_job.lower      = addr[15:0];
        o_job.data       = i_data_byte;
        o_job.close_sum  = 8'h00 - n_record_sum;
        o_job.start_addr = r_start_address;
        o_job.start_sum  = 8'h00 - (ihex_enc_pkg::START_SUM_BASE + start_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address  <= '0;
            r_image_length  <= '0;
            r_start_given   <= 1'b0;
            r_start_address <= '0;
            r_byte_offset   <= '0;
            r_record_sum    <= '0;
            r_last_upper    <= '0;
            r_record_pos    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ihex_enc_pkg::CFG_BASE_ADDRESS:  r_base_address  <= i_cfg_data;
                    ihex_enc_pkg::CFG_IMAGE_LENGTH:  r_image_length  <= i_cfg_data;
                    ihex_enc_pkg::CFG_START_GIVEN:   r_start_given   <= i_cfg_data[0];
                    ihex_enc_pkg::CFG_START_ADDRESS: r_start_address <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (i_mode == ihex_enc_pkg::MODE_DATA) begin
                    if (in_range) begin
                        r_byte_offset <= r_byte_offset + 32'd1;
                        r_record_pos  <= close_rec ? '0 : n_record_pos;
                        r_record_sum  <= close_rec ? 8'h00 : n_record_sum;
                        if (ext_needed) begin
                            r_last_upper <= addr[31:16];
                        end
                    end
                end else if (!fin_err) begin
                    r_byte_offset <= '0;
                    r_record_sum  <= '0;
                    r_last_upper  <= '0;
                    r_record_pos  <= '0;
                end
            end
        end
    end

endmodule

// File: rtl/ihex_enc_serial.sv
// Character serializer: walks the records of one job and drives the output register.
module ihex_enc_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ihex_enc_pkg::t_job i_job,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output logic [7:0]         o_character,
    output logic               o_last,
    output logic               o_error
);

    localparam int LineChars = 21;

    typedef enum logic [2:0] {
        SEG_EXT,
        SEG_HDR,
        SEG_DATA,
        SEG_CLOSE,
        SEG_START,
        SEG_END,
        SEG_ERR
    } t_seg;

    logic               r_job_valid;
    ihex_enc_pkg::t_job r_job;
    t_seg               r_seg;
    logic [4:0]         r_idx;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_last;
    logic               r_out_error;

    t_seg                   first_seg;
    t_seg                   next_seg;
    logic                   has_next;
    logic [4:0]             seg_last;
    logic                   seg_end;
    logic                   advance;
    logic                   job_done;
    logic [LineChars*8-1:0] line;
    logic [7:0]             ch;

    always_comb begin
        if (i_job.err) begin
            first_seg = SEG_ERR;
        end else if (i_job.fin) begin
            first_seg = i_job.start ? SEG_START : SEG_END;
        end else if (i_job.ext) begin
            first_seg = SEG_EXT;
        end else if (i_job.hdr) begin
            first_seg = SEG_HDR;
        end else begin
            first_seg = SEG_DATA;
        end
    end

    always_comb begin
        next_seg = SEG_ERR;
        has_next = 1'b0;
        seg_last = 5'd0;
        case (r_seg)
            SEG_EXT: begin
                seg_last = 5'd16;
                next_seg = SEG_HDR;
                has_next = 1'b1;
            end
            SEG_HDR: begin
                seg_last = 5'd8;
                next_seg = SEG_DATA;
                has_next = 1'b1;
            end
            SEG_DATA: begin
                seg_last = 5'd1;
                next_seg = SEG_CLOSE;
                has_next = r_job.close;
            end
            SEG_CLOSE: seg_last = 5'd3;
            SEG_START: begin
                seg_last = 5'd20;
                next_seg = SEG_END;
                has_next = 1'b1;
            end
            SEG_END: seg_last = 5'd12;
            SEG_ERR: seg_last = 5'd0;
            default: ;
        endcase
    end

    // Each segment's text is laid out left-aligned in one line and picked by index.
    always_comb begin
        line = '0;
        case (r_seg)
            SEG_EXT: line = {ihex_enc_pkg::EXT_HEAD,
                             ihex_enc_pkg::hex_byte(r_job.upper[15:8]),
                             ihex_enc_pkg::hex_byte(r_job.upper[7:0]),
                             ihex_enc_pkg::hex_byte(r_job.ext_sum),
                             ihex_enc_pkg::CHAR_CR, ihex_enc_pkg::CHAR_LF, 32'h0};
            SEG_HDR: line = {ihex_enc_pkg::CHAR_COLON,
                             ihex_enc_pkg::hex_byte(r_job.len),
                             ihex_enc_pkg::hex_byte(r_job.lower[15:8]),
                             ihex_enc_pkg::hex_byte(r_job.lower[7:0]),
                             ihex_enc_pkg::TYPE_DATA, 96'h0};
            SEG_DATA: line = {ihex_enc_pkg::hex_byte(r_job.data), 152'h0};
            SEG_CLOSE: line = {ihex_enc_pkg::hex_byte(r_job.close_sum),
                               ihex_enc_pkg::CHAR_CR, ihex_enc_pkg::CHAR_LF, 136'h0};
            SEG_START: line = {ihex_enc_pkg::START_HEAD,
                               ihex_enc_pkg::hex_byte(r_job.start_addr[31:24]),
                               ihex_enc_pkg::hex_byte(r_job.start_addr[23:16]),
                               ihex_enc_pkg::hex_byte(r_job.start_addr[15:8]),
                               ihex_enc_pkg::hex_byte(r_job.start_addr[7:0]),
                               ihex_enc_pkg::hex_byte(r_job.start_sum),
                               ihex_enc_pkg::CHAR_CR, ihex_enc_pkg::CHAR_LF};
            SEG_END: line = {ihex_enc_pkg::END_TEXT,
                             ihex_enc_pkg::CHAR_CR, ihex_enc_pkg::CHAR_LF, 64'h0};
            SEG_ERR: line = {ihex_enc_pkg::CHAR_ERROR, 160'h0};
            default: ;
        endcase
    end

    assign ch       = line[(LineChars - 1 - int'(r_idx)) * 8 +: 8];
    assign seg_end  = r_idx == seg_last;
    assign advance  = r_job_valid && (!r_out_valid || !i_stall);
    assign job_done = advance && seg_end && !has_next;
    assign o_ready  = !r_job_valid || job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_seg       <= SEG_ERR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_char  <= ch;
                r_out_last  <= seg_end && !has_next;
                r_out_error <= r_seg == SEG_ERR;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_load) begin
                r_job_valid <= 1'b1;
                r_job       <= i_job;
                r_seg       <= first_seg;
                r_idx       <= '0;
            end else if (job_done) begin
                r_job_valid <= 1'b0;
            end else if (advance) begin
                if (seg_end) begin
                    r_seg <= next_seg;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;
    assign o_error     = r_out_error;

endmodule

// File: rtl/intel_hex_record_encoder.sv
// Top level of the streaming Intel HEX record encoder.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_mode, i_data_byte
//  output    out        o_valid / i_stall  o_character, o_last, o_error
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One character leaves per cycle while i_stall is low, so the serializer sets the rate:
// a data byte yields 2 characters, plus 9 when it opens a record, 17 more for an extended
// address record and 4 when it closes one. A finish yields 13, 34 with a start address record,
// or 1 if premature. A byte past the image length is accepted and produces nothing.
// The synchronous reset clears the configuration, the image state and both valid flags.
// o_stall is high while the serializer holds a job that is not on its final transfer;
// the output register holds its character while i_stall is high.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_error
);

    logic               ready;
    logic               accept;
    logic               load;
    ihex_enc_pkg::t_job job;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    ihex_enc_front #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_load      (load),
        .o_job       (job)
    );

    ihex_enc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_stall     (i_stall),
        .o_ready     (ready),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

// File: rtl/ihex_enc_checker.sv
// Port-level checks for the Intel HEX record encoder, bound to the top level.
module ihex_enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [7:0] i_character,
    input logic       i_last,
    input logic       i_error
);

    // An error result is always a single transfer on its own.
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_last)
        else $error("error result without last");

    a_error_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_character == ihex_enc_pkg::CHAR_ERROR)
        else $error("error result carries a nonzero character");

    // A good item ends on the LF of a record, or on a data digit while its record stays open.
    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last && !i_error |->
            (i_character == ihex_enc_pkg::CHAR_LF)
            || (i_character >= 8'h30 && i_character <= 8'h39)
            || (i_character >= 8'h41 && i_character <= 8'h46))
        else $error("item ends on a character other than LF or a hex digit");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_character)
            && $stable(i_last) && $stable(i_error))
        else $error("stalled output changed");

endmodule

bind intel_hex_record_encoder ihex_enc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_character (o_character),
    .i_last      (o_last),
    .i_error     (o_error)
);

// File: tb/tb_intel_hex_record_encoder.sv
// Self-checking testbench for the streaming Intel HEX record encoder.
module tb_intel_hex_record_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RECORD_BYTES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_hex_char;

    // Predicts the hex text of each accepted transfer and checks it on the way out.
    class hex_text_scoreboard #(int REC_BYTES = 16);
        logic [31:0] base_addr;
        logic [31:0] image_len;
        logic        start_given;
        logic [31:0] start_addr;
        logic [31:0] byte_count;
        logic [7:0]  rec_sum;
        logic [7:0]  rec_fill;
        logic [15:0] upper_seen;
        t_hex_char   text_q[$];
        string       hex_digits;
        int          failures;
        int          chars_checked;
        int          images_done;
        int          errors_flagged;

        function new();
            base_addr      = '0;
            image_len      = '0;
            start_given    = 1'b0;
            start_addr     = '0;
            byte_count     = '0;
            rec_sum        = '0;
            rec_fill       = '0;
            upper_seen     = '0;
            hex_digits     = "0123456789ABCDEF";
            failures       = 0;
            chars_checked  = 0;
            images_done    = 0;
            errors_flagged = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                ihex_enc_pkg::CFG_BASE_ADDRESS:  base_addr   = value;
                ihex_enc_pkg::CFG_IMAGE_LENGTH:  image_len   = value;
                ihex_enc_pkg::CFG_START_GIVEN:   start_given = value[0];
                ihex_enc_pkg::CFG_START_ADDRESS: start_addr  = value;
                default: ;
            endcase
        endfunction

        function void put_char(logic [7:0] c);
            t_hex_char e;
            e.ch   = c;
            e.last = 1'b0;
            e.err  = 1'b0;
            text_q.push_back(e);
        endfunction

        function void put_text(string s);
            for (int i = 0; i < s.len(); i++) put_char(s[i]);
        endfunction

        function void put_hex8(logic [7:0] v);
            put_char(8'(hex_digits[v[7:4]]));
            put_char(8'(hex_digits[v[3:0]]));
        endfunction

        // Checksum is the two's complement of the byte sum, then CR LF.
        function void close_record(logic [7:0] sum);
            put_hex8(8'h00 - sum);
            put_char(ihex_enc_pkg::CHAR_CR);
            put_char(ihex_enc_pkg::CHAR_LF);
        endfunction

        function int note_item(logic mode, logic [7:0] data);
            int          prior_size;
            t_hex_char   e;
            logic [31:0] addr;
            logic [31:0] left;
            logic [15:0] upper;
            logic [15:0] lower;
            logic [7:0]  len;
            prior_size = text_q.size();
            if (mode == ihex_enc_pkg::MODE_DATA) begin
                // Bytes past the image length vanish without a trace.
                if (byte_count >= image_len) return 0;
                if (rec_fill == 8'd0) begin
                    addr  = base_addr + byte_count;
                    upper = addr[31:16];
                    lower = addr[15:0];
                    if (upper != upper_seen) begin
                        put_text(":02000004");
                        put_hex8(upper[15:8]);
                        put_hex8(upper[7:0]);
                        close_record(8'h06 + upper[15:8] + upper[7:0]);
                        upper_seen = upper;
                    end
                    left = image_len - byte_count;
                    len  = (left < 32'(REC_BYTES)) ? left[7:0] : 8'(REC_BYTES);
                    put_char(ihex_enc_pkg::CHAR_COLON);
                    put_hex8(len);
                    put_hex8(lower[15:8]);
                    put_hex8(lower[7:0]);
                    put_text("00");
                    rec_sum = len + lower[15:8] + lower[7:0];
                end
                put_hex8(data);
                rec_sum    = rec_sum + data;
                rec_fill   = rec_fill + 8'd1;
                byte_count = byte_count + 32'd1;
                if (rec_fill >= 8'(REC_BYTES) || byte_count >= image_len) begin
                    close_record(rec_sum);
                    rec_fill = '0;
                    rec_sum  = '0;
                end
            end else if (byte_count < image_len || rec_fill != 8'd0) begin
                e.ch   = ihex_enc_pkg::CHAR_ERROR;
                e.last = 1'b1;
                e.err  = 1'b1;
                text_q.push_back(e);
                errors_flagged++;
                return 1;
            end else begin
                if (start_given) begin
                    put_text(":04000005");
                    put_hex8(start_addr[31:24]);
                    put_hex8(start_addr[23:16]);
                    put_hex8(start_addr[15:8]);
                    put_hex8(start_addr[7:0]);
                    close_record(8'h09 + start_addr[31:24] + start_addr[23:16]
                                 + start_addr[15:8] + start_addr[7:0]);
                end
                put_text(":00000001FF");
                put_char(ihex_enc_pkg::CHAR_CR);
                put_char(ihex_enc_pkg::CHAR_LF);
                byte_count = '0;
                rec_sum    = '0;
                upper_seen = '0;
                rec_fill   = '0;
                images_done++;
            end
            if (text_q.size() > prior_size) begin
                e      = text_q.pop_back();
                e.last = 1'b1;
                text_q.push_back(e);
            end
            return text_q.size() - prior_size;
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic err);
            t_hex_char e;
            if (text_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected character %h last %b error %b", ch, last, err);
                return;
            end
            e = text_q.pop_front();
            chars_checked++;
            if (e.ch !== ch || e.last !== last || e.err !== err) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch at character %0d: expected %h/%b/%b, got %h/%b/%b",
                             chars_checked, e.ch, e.last, e.err, ch, last, err);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic        i_mode;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_character;
    logic        o_last;
    logic        o_error;

    hex_text_scoreboard #(RECORD_BYTES) sb;
    int items_encoded = 0;
    int sender_odds   = 0;
    int stall_odds    = 0;
    bit no_idle       = 1'b0;
    bit long_hold_req = 1'b0;

    intel_hex_record_encoder #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_char(o_character, o_last, o_error);
    end

    // The receiver backs off in bursts; a long hold-off lets the block fill up.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!no_idle && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] data);
        if (!no_idle && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        if (sb.note_item(mode, data) > 0) items_encoded++;
        @(negedge i_clk);
    endtask

    // Stops offering transfers until every predicted character has come out.
    task automatic wait_all_chars();
        i_valid <= 1'b0;
        while (sb.text_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        sb.set_reg(index, value);
        @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] base, input logic [31:0] len,
                             input logic given, input logic [31:0] start);
        write_reg(ihex_enc_pkg::CFG_BASE_ADDRESS, base);
        write_reg(ihex_enc_pkg::CFG_IMAGE_LENGTH, len);
        write_reg(ihex_enc_pkg::CFG_START_GIVEN, {31'b0, given});
        write_reg(ihex_enc_pkg::CFG_START_ADDRESS, start);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_image(input bit with_hold);
        logic [31:0] base;
        logic [31:0] len;
        int          cut;
        int          extra;
        case ($urandom_range(0, 3))
            0: base = $urandom;
            1: base = {16'($urandom), 16'hFFF0 | 16'($urandom_range(0, 15))};
            2: base = 32'($urandom_range(0, 255));
            default: base = {16'hFFFF, 16'($urandom)};
        endcase
        len = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(60, 90))
                                          : 32'($urandom_range(0, 40));
        if (with_hold) len = 32'd48;
        wait_all_chars();
        load_regs(base, len, 1'($urandom_range(0, 1)), $urandom);
        sender_odds = 4 * $urandom_range(0, 2);
        stall_odds  = 4 * $urandom_range(0, 2);
        long_hold_req = with_hold;
        // Now and then a finish comes too early, or stray bytes follow the image.
        cut   = ($urandom_range(0, 7) == 0 && len != 0) ? $urandom_range(0, len - 1) : -1;
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        for (int k = 0; k < len; k++) begin
            if (k == cut) send_item(ihex_enc_pkg::MODE_FINISH, 8'($urandom));
            send_item(ihex_enc_pkg::MODE_DATA, 8'($urandom));
        end
        repeat (extra) send_item(ihex_enc_pkg::MODE_DATA, 8'($urandom));
        send_item(ihex_enc_pkg::MODE_FINISH, 8'($urandom));
    endtask

    initial begin
        logic [7:0] pattern[10];
        int         image_no;
        sb          = new();
        pattern     = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};
        image_no    = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = ihex_enc_pkg::CFG_BASE_ADDRESS;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_mode      = ihex_enc_pkg::MODE_DATA;
        i_data_byte = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sender_odds = 3;
        stall_odds  = 3;

        // Image that wraps the 32-bit address space inside its only record.
        load_regs(32'hFFFF_FFF8, 32'd10, 1'b1, 32'hFFFF_FFFF);
        send_item(ihex_enc_pkg::MODE_FINISH, 8'h00);
        foreach (pattern[k]) send_item(ihex_enc_pkg::MODE_DATA, pattern[k]);
        send_item(ihex_enc_pkg::MODE_DATA, 8'h3C);
        send_item(ihex_enc_pkg::MODE_FINISH, 8'hFF);

        // Empty image: only the end record.
        wait_all_chars();
        load_regs(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
        send_item(ihex_enc_pkg::MODE_DATA, 8'h12);
        send_item(ihex_enc_pkg::MODE_FINISH, 8'h00);

        // Length shrunk under an open record, then grown again to close it.
        wait_all_chars();
        load_regs(32'h0001_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        for (int k = 0; k < 5; k++) send_item(ihex_enc_pkg::MODE_DATA, 8'($urandom));
        wait_all_chars();
        load_regs(32'h0001_FFFC, 32'd3, 1'b1, 32'h0000_0000);
        send_item(ihex_enc_pkg::MODE_FINISH, 8'h00);
        send_item(ihex_enc_pkg::MODE_DATA, 8'h99);
        wait_all_chars();
        load_regs(32'h0001_FFFC, 32'd7, 1'b1, 32'h0000_0000);
        send_item(ihex_enc_pkg::MODE_DATA, 8'($urandom));
        send_item(ihex_enc_pkg::MODE_DATA, 8'($urandom));
        send_item(ihex_enc_pkg::MODE_FINISH, 8'h00);

        while (items_encoded < 430) begin
            no_idle = (items_encoded > 380);
            run_random_image(image_no == 2);
            image_no++;
        end

        no_idle = 1'b1;
        wait_all_chars();
        repeat (40) @(negedge i_clk);
        $display("Encoded %0d complete images and flagged %0d early finishes;",
                 sb.images_done, sb.errors_flagged);
        $display("%0d characters checked, %0d failures.", sb.chars_checked, sb.failures);
        if (sb.failures == 0 && sb.text_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
